@@ hdl/shamh_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 message hasher.
`timescale 1ns / 1ps

package shamh_pkg;

  localparam logic KindData   = 1'b0;
  localparam logic KindFinish = 1'b1;

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [5:0] LenFill   = 6'd56;
  localparam logic [5:0] FullFill  = 6'd63;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [2:0] LastWord  = 3'd7;

  localparam logic [31:0] IvWords [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StComp,
    StFold,
    StOut
  } state_e;

  typedef struct packed {
    logic       push;
    logic [7:0] push_byte;
    logic       load;
    logic       rnd;
    logic [5:0] rnd_idx;
    logic       fold;
    logic       reinit;
    logic [2:0] out_idx;
  } ctl_t;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

@@ hdl/shamh_sched.sv @@
// Block buffer and message schedule: byte shift line that doubles as the W window.
`timescale 1ns / 1ps

module shamh_sched import shamh_pkg::*; (
  input  logic        clk_i,
  input  ctl_t        ctl_i,
  output logic [31:0] w_o
);

  logic [511:0] blk_q, blk_d;
  logic [31:0]  w_new;

  // window holds w[t] .. w[t+15], w[t] in the top word
  assign w_new = blk_q[511:480] + ssig0(blk_q[479:448]) + blk_q[223:192]
               + ssig1(blk_q[63:32]);
  assign w_o = blk_q[511:480];

  always_comb begin
    blk_d = blk_q;
    if (ctl_i.push) begin
      blk_d = {blk_q[503:0], ctl_i.push_byte};
    end else if (ctl_i.rnd) begin
      blk_d = {blk_q[479:0], w_new};
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

endmodule

@@ hdl/shamh_core.sv @@
// Round datapath: working variables, one round per cycle, and chaining words.
`timescale 1ns / 1ps

module shamh_core import shamh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_t        ctl_i,
  input  logic [31:0] w_i,
  output logic [31:0] digest_o
);

  logic [31:0] wk_q [8];
  logic [31:0] wk_d [8];
  logic [31:0] chain_q [8];
  logic [31:0] chain_d [8];
  logic [31:0] t1, t2;

  assign t1 = wk_q[7] + bsig1(wk_q[4]) + ((wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]))
            + RoundK[ctl_i.rnd_idx] + w_i;
  assign t2 = bsig0(wk_q[0]) + ((wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2])
            ^ (wk_q[1] & wk_q[2]));

  always_comb begin
    wk_d = wk_q;
    if (ctl_i.load) begin
      wk_d = chain_q;
    end else if (ctl_i.rnd) begin
      wk_d[7] = wk_q[6];
      wk_d[6] = wk_q[5];
      wk_d[5] = wk_q[4];
      wk_d[4] = wk_q[3] + t1;
      wk_d[3] = wk_q[2];
      wk_d[2] = wk_q[1];
      wk_d[1] = wk_q[0];
      wk_d[0] = t1 + t2;
    end
  end

  always_comb begin
    chain_d = chain_q;
    if (ctl_i.reinit) begin
      chain_d = IvWords;
    end else if (ctl_i.fold) begin
      for (int i = 0; i < 8; i++) begin
        chain_d[i] = chain_q[i] + wk_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wk_q <= wk_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= IvWords;
    end else begin
      chain_q <= chain_d;
    end
  end

  assign digest_o = chain_q[ctl_i.out_idx];

endmodule

@@ hdl/shamh_ctrl.sv @@
// Sequencer: byte intake, padding, round counting and digest readout.
`timescale 1ns / 1ps

module shamh_ctrl import shamh_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  input  logic     out_stall_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  output ctl_t     ctl_o
);

  state_e      st_q, st_d;
  logic [5:0]  fill_q, fill_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [60:0] cnt_q, cnt_d;
  logic [2:0]  oidx_q, oidx_d;
  logic        fin_q, fin_d;
  logic        first_q, first_d;
  logic        len_q, len_d;
  logic [63:0] len_bits;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;

  assign len_bits = {cnt_q, 3'b000};
  assign len_byte = len_bits[{~fill_q[2:0], 3'b000} +: 8];

  always_comb begin
    if (first_q) begin
      pad_byte = PadByte;
    end else if (len_q || fill_q == LenFill) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_item_i.kind == KindFinish) begin
            st_d = StPad;
          end else if (fill_q == FullFill) begin
            st_d = StComp;
          end
        end
      end
      StPad: begin
        if (fill_q == FullFill) begin
          st_d = StComp;
        end
      end
      StComp: begin
        if (rnd_q == LastRound) begin
          st_d = StFold;
        end
      end
      StFold: begin
        priority if (len_q) begin
          st_d = StOut;
        end else if (fin_q) begin
          st_d = StPad;
        end else begin
          st_d = StIdle;
        end
      end
      StOut: begin
        if (!out_stall_i && oidx_q == LastWord) begin
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  // outputs and counters
  always_comb begin
    ctl_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    fill_d      = fill_q;
    rnd_d       = rnd_q;
    cnt_d       = cnt_q;
    oidx_d      = oidx_q;
    fin_d       = fin_q;
    first_d     = first_q;
    len_d       = len_q;
    ctl_o.rnd_idx = rnd_q;
    ctl_o.out_idx = oidx_q;
    unique case (st_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_item_i.kind == KindFinish) begin
            fin_d   = 1'b1;
            first_d = 1'b1;
          end else begin
            ctl_o.push      = 1'b1;
            ctl_o.push_byte = in_item_i.data_byte;
            ctl_o.load      = (fill_q == FullFill);
            fill_d          = fill_q + 6'd1;
            cnt_d           = cnt_q + 61'd1;
          end
        end
      end
      StPad: begin
        ctl_o.push      = 1'b1;
        ctl_o.push_byte = pad_byte;
        ctl_o.load      = (fill_q == FullFill);
        fill_d          = fill_q + 6'd1;
        first_d         = 1'b0;
        if (!first_q && fill_q == LenFill) begin
          len_d = 1'b1;
        end
      end
      StComp: begin
        ctl_o.rnd = 1'b1;
        rnd_d     = rnd_q + 6'd1;
      end
      StFold: begin
        ctl_o.fold = 1'b1;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == LastWord) begin
            ctl_o.reinit = 1'b1;
            cnt_d        = '0;
            fin_d        = 1'b0;
            len_d        = 1'b0;
          end
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      fill_q  <= '0;
      rnd_q   <= '0;
      cnt_q   <= '0;
      oidx_q  <= '0;
      fin_q   <= 1'b0;
      first_q <= 1'b0;
      len_q   <= 1'b0;
    end else begin
      st_q    <= st_d;
      fill_q  <= fill_d;
      rnd_q   <= rnd_d;
      cnt_q   <= cnt_d;
      oidx_q  <= oidx_d;
      fin_q   <= fin_d;
      first_q <= first_d;
      len_q   <= len_d;
    end
  end

  a_out_empty_buf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StOut |-> fill_q == 6'd0)
    else $error("digest readout with a partly filled block");

  a_rounds_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StComp && rnd_q == LastRound) |=> st_q == StFold)
    else $error("compression did not end after the last round");

  a_len_in_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q |-> fin_q)
    else $error("length phase outside a finish");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StIdle |-> (!fin_q && !len_q && rnd_q == 6'd0 && oidx_q == 3'd0))
    else $error("idle with finish state left over");

endmodule

@@ hdl/sha256_message_hasher.sv @@
// SHA-256 message hasher top level: byte intake, padding and digest readout.
//
//   channel  dir  handshake                   item
//   in       in   in_valid_i / in_stall_o     in_item_i  (kind, data_byte)
//   out      out  out_valid_o / out_stall_i   out_item_o (digest_word, word_index, last_word)
//
// Data bytes are taken while idle; the byte that fills a 64-byte block starts a compression
// (64 rounds of the shared round unit plus one chaining add).
// A finish pads one byte per cycle up to the block end, runs one or two
// compressions, then offers eight digest words, one per cycle when not stalled.
// Reset (asynchronous, active low) loads the initial hash values and clears counts.
// Input is stalled whenever the sequencer is not idle; a stalled digest word holds.
`timescale 1ns / 1ps

module sha256_message_hasher import shamh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  ctl_t        ctl;
  logic [31:0] w_word;
  logic [31:0] digest;

  shamh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .ctl_o       (ctl)
  );

  shamh_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .w_o   (w_word)
  );

  shamh_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .w_i      (w_word),
    .digest_o (digest)
  );

  assign out_item_o.digest_word = digest;
  assign out_item_o.word_index  = ctl.out_idx;
  assign out_item_o.last_word   = (ctl.out_idx == LastWord);

endmodule

@@ tb/sha256_digest_checker.sv @@
// Digest checker: tracks the SHA-256 state from accepted items and checks every digest word.
`timescale 1ns / 1ps

module sha256_digest_checker import shamh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LengthSlot = 6'd56;
  localparam logic [5:0] BlockEnd = 6'd63;

  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  logic [31:0] hash_state [8];
  logic [7:0]  block_bytes [64];
  logic [5:0]  block_fill;
  logic [60:0] msg_bytes;
  out_item_t   digest_fifo [$];
  int          fails;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned s);
    return (x >> s) | (x << (32 - s));
  endfunction

  function automatic void restart_hash();
    hash_state = HashInit;
    block_fill = '0;
    msg_bytes  = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    v = hash_state;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    block_bytes[block_fill] = b;
    if (block_fill == BlockEnd) begin
      compress_block();
      block_fill = '0;
    end else begin
      block_fill = block_fill + 6'd1;
    end
  endfunction

  // pad, append bit length, queue the eight words, start a fresh message
  function automatic void pad_and_emit();
    logic [63:0] bit_len;
    out_item_t   word;
    bit_len = {msg_bytes, 3'b000};
    absorb_byte(PadMarker);
    while (block_fill != LengthSlot) absorb_byte(8'h00);
    for (int i = 0; i < 8; i++) absorb_byte(bit_len[63 - 8*i -: 8]);
    for (int i = 0; i < 8; i++) begin
      word.digest_word = hash_state[i];
      word.word_index  = 3'(i);
      word.last_word   = (i == 7);
      digest_fifo = {digest_fifo, word};
    end
    restart_hash();
  endfunction

  function automatic void check_word(input out_item_t got);
    out_item_t want;
    if (digest_fifo.size() == 0) begin
      fails++;
      $display("%0t: digest word with none expected: word %h index %0d last %b", $time,
               got.digest_word, got.word_index, got.last_word);
      return;
    end
    want = digest_fifo.pop_front();
    if (got.digest_word !== want.digest_word) begin
      fails++;
      $display("%0t: digest_word mismatch: expected %h actual %h", $time,
               want.digest_word, got.digest_word);
    end
    if (got.word_index !== want.word_index) begin
      fails++;
      $display("%0t: word_index mismatch: expected %0d actual %0d", $time,
               want.word_index, got.word_index);
    end
    if (got.last_word !== want.last_word) begin
      fails++;
      $display("%0t: last_word mismatch: expected %b actual %b", $time,
               want.last_word, got.last_word);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_hash();
      digest_fifo.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_word(out_item_i);
      if (in_valid_i && !in_stall_i) begin
        if (in_item_i.kind == KindFinish) begin
          pad_and_emit();
        end else begin
          absorb_byte(in_item_i.data_byte);
          msg_bytes = msg_bytes + 61'd1;
        end
      end
      fail_count_o <= fails;
      pending_o <= digest_fifo.size();
    end
  end

endmodule

@@ tb/sha256_message_hasher_test.sv @@
// Testbench top for the SHA-256 message hasher: clock, reset, item stimulus and verdict.
`timescale 1ns / 1ps

module sha256_message_hasher_test;
  import shamh_pkg::*;

  localparam int RandomItems   = 150;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 300;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  int fail_count;
  int pending;
  int quiet_cycles;
  int items_sent;
  int send_idle_pct;
  int recv_stall_pct;

  sha256_message_hasher dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  sha256_digest_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic pick_phase();
    case ($urandom_range(3))
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 65;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 65;
      end
      default: begin
        send_idle_pct = 16;
        recv_stall_pct = 16;
      end
    endcase
  endtask

  task automatic send_item(input logic kind, input logic [7:0] b);
    in_item_t item;
    item.kind = kind;
    item.data_byte = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_message(input int len);
    pick_phase();
    for (int i = 0; i < len; i++) send_item(KindData, 8'($urandom));
    send_item(KindFinish, 8'($urandom));
  endtask

  initial begin
    int len;
    in_valid <= 1'b0;
    in_item <= '0;
    rst_n <= 1'b0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message, then a repeated finish whose data byte must be ignored
    send_item(KindFinish, 8'h00);
    pick_phase();
    send_item(KindFinish, 8'hFF);
    // "abc"
    pick_phase();
    send_item(KindData, 8'h61);
    send_item(KindData, 8'h62);
    send_item(KindData, 8'h63);
    send_item(KindFinish, 8'h00);
    // byte extremes
    pick_phase();
    send_item(KindData, 8'h00);
    send_item(KindData, 8'hFF);
    send_item(KindData, 8'h80);
    send_item(KindFinish, 8'hA5);

    // random messages, biased toward short lengths and the padding boundaries
    while (items_sent < RandomItems) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(12);
        6, 7: begin
          case ($urandom_range(5))
            0: len = 55;
            1: len = 56;
            2: len = 57;
            3: len = 63;
            4: len = 64;
            default: len = 65;
          endcase
        end
        default: len = $urandom_range(70);
      endcase
      send_message(len);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
